@@ rtl/core/afsk_envelope_demodulator_assert.svh @@
// ---------------------------------------------------------------------------
// AFSK demodulator assertion macros
// Shared concurrent assertion helpers for the RTL.
// ---------------------------------------------------------------------------
`ifndef AFSK_ENVELOPE_DEMODULATOR_ASSERT_SVH
`define AFSK_ENVELOPE_DEMODULATOR_ASSERT_SVH

// implication check: antecedent implies consequent in the same cycle
`define AFSK_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle check
`define AFSK_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");

`endif

@@ rtl/core/afsk_pkg.sv @@
// ---------------------------------------------------------------------------
// AFSK package
// Types, coefficient tables and helpers of the envelope demodulator.
// ---------------------------------------------------------------------------
package afsk_pkg;

  localparam int unsigned BpDesign = 36;
  localparam int unsigned LpDesign = 24;
  localparam int unsigned SoftBits = 18;
  localparam int unsigned EnergyBits = 16;
  localparam int unsigned BpOutBits = 16;

  typedef enum logic [1:0] {
    SEL_SPACE = 2'd0,
    SEL_MARK  = 2'd1,
    SEL_ENV   = 2'd2
  } coef_sel_e;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_BPS   = 6'b000010,
    ST_BPM   = 6'b000100,
    ST_ENVS  = 6'b001000,
    ST_ENVM  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  typedef struct packed {
    logic      shift_sample;
    logic      clr_acc;
    logic      mac_en;
    coef_sel_e sel;
    logic      fin_space_bp;
    logic      fin_mark_bp;
    logic      fin_space_env;
    logic      fin_mark_env;
    logic      load_out;
  } dp_cmd_t;

  function automatic logic signed [17:0] coef_lookup(input coef_sel_e sel,
                                                     input int unsigned idx);
    logic signed [17:0] r;
    r = '0;
    case (sel)
      SEL_SPACE: begin
        case (idx)
          0: r = 113;    1: r = 86;     2: r = 40;     3: r = -57;
          4: r = -233;   5: r = -501;   6: r = -843;   7: r = -1207;
          8: r = -1509;  9: r = -1653;  10: r = -1550; 11: r = -1147;
          12: r = -445;  13: r = 490;   14: r = 1535;  15: r = 2529;
          16: r = 3307;  17: r = 3735;  18: r = 3735;  19: r = 3307;
          20: r = 2529;  21: r = 1535;  22: r = 490;   23: r = -445;
          24: r = -1147; 25: r = -1550; 26: r = -1653; 27: r = -1509;
          28: r = -1207; 29: r = -843;  30: r = -501;  31: r = -233;
          32: r = -57;   33: r = 40;    34: r = 86;    35: r = 113;
          default: r = '0;
        endcase
      end
      SEL_MARK: begin
        case (idx)
          0: r = 0;      1: r = -111;   2: r = -242;   3: r = -344;
          4: r = -301;   5: r = 0;      6: r = 555;    7: r = 1161;
          8: r = 1452;   9: r = 1089;   10: r = 0;     11: r = -1483;
          12: r = -2701; 13: r = -2976; 14: r = -1984; 15: r = 0;
          16: r = 2179;  17: r = 3592;  18: r = 3592;  19: r = 2179;
          20: r = 0;     21: r = -1984; 22: r = -2976; 23: r = -2701;
          24: r = -1483; 25: r = 0;     26: r = 1089;  27: r = 1452;
          28: r = 1161;  29: r = 555;   30: r = 0;     31: r = -301;
          32: r = -344;  33: r = -242;  34: r = -111;  35: r = 0;
          default: r = '0;
        endcase
      end
      SEL_ENV: begin
        case (idx)
          0: r = 11;     1: r = 45;     2: r = 119;    3: r = 267;
          4: r = 512;    5: r = 861;    6: r = 1303;   7: r = 1802;
          8: r = 2309;   9: r = 2762;   10: r = 3104;  11: r = 3288;
          12: r = 3288;  13: r = 3104;  14: r = 2762;  15: r = 2309;
          16: r = 1802;  17: r = 1303;  18: r = 861;   19: r = 512;
          20: r = 267;   21: r = 119;   22: r = 45;    23: r = 11;
          default: r = '0;
        endcase
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/afsk_ctrl.sv @@
// ---------------------------------------------------------------------------
// AFSK controller
// Sequences the shared MAC over band-pass and envelope taps, one per cycle.
// ---------------------------------------------------------------------------
module afsk_ctrl #(
  parameter int unsigned BpTaps = 36,
  parameter int unsigned LpTaps = 24,
  parameter int unsigned CntW   = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  input  logic             out_free_i,
  output logic             busy_o,
  output logic [CntW-1:0]  tap_o,
  output afsk_pkg::dp_cmd_t cmd_o
);
  import afsk_pkg::*;

  state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      drain_q, drain_d;

  localparam logic [CntW-1:0] BpLast = CntW'(BpTaps - 1);
  localparam logic [CntW-1:0] LpLast = CntW'(LpTaps - 1);
  // drain covers the operand register and then the accumulator after the last tap
  localparam logic [1:0]      DrainFin = 2'd2;

  assign busy_o = (state_q != ST_IDLE);
  assign tap_o  = cnt_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    drain_d = 2'd0;
    cmd_o   = '0;
    cmd_o.sel = SEL_SPACE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire_i) begin
          cmd_o.shift_sample = 1'b1;
          cmd_o.clr_acc = 1'b1;
          state_d = ST_BPS;
          cnt_d = '0;
        end
      end
      ST_BPS: begin
        cmd_o.sel = SEL_SPACE;
        cmd_o.mac_en = (drain_q == 2'd0);
        if (drain_q == DrainFin) begin
          cmd_o.fin_space_bp = 1'b1;
          cmd_o.clr_acc = 1'b1;
          cnt_d = '0;
          state_d = ST_BPM;
        end else if (drain_q != 2'd0) begin
          drain_d = drain_q + 2'd1;
        end else if (cnt_q == BpLast) begin
          drain_d = 2'd1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_BPM: begin
        cmd_o.sel = SEL_MARK;
        cmd_o.mac_en = (drain_q == 2'd0);
        if (drain_q == DrainFin) begin
          cmd_o.fin_mark_bp = 1'b1;
          cmd_o.clr_acc = 1'b1;
          cnt_d = '0;
          state_d = ST_ENVS;
        end else if (drain_q != 2'd0) begin
          drain_d = drain_q + 2'd1;
        end else if (cnt_q == BpLast) begin
          drain_d = 2'd1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_ENVS: begin
        cmd_o.sel = SEL_ENV;
        cmd_o.mac_en = (drain_q == 2'd0);
        if (drain_q == DrainFin) begin
          cmd_o.fin_space_env = 1'b1;
          cmd_o.clr_acc = 1'b1;
          cnt_d = '0;
          state_d = ST_ENVM;
        end else if (drain_q != 2'd0) begin
          drain_d = drain_q + 2'd1;
        end else if (cnt_q == LpLast) begin
          drain_d = 2'd1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_ENVM: begin
        cmd_o.sel = SEL_ENV;
        cmd_o.mac_en = (drain_q == 2'd0);
        if (drain_q == DrainFin) begin
          cmd_o.fin_mark_env = 1'b1;
          state_d = ST_OUT;
        end else if (drain_q != 2'd0) begin
          drain_d = drain_q + 2'd1;
        end else if (cnt_q == LpLast) begin
          drain_d = 2'd1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (out_free_i) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      drain_q <= 2'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drain_q <= drain_d;
    end
  end

  `include "afsk_envelope_demodulator_assert.svh"
  `AFSK_ASSERT_IMP(a_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q))
  `AFSK_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, busy_o, !cmd_o.shift_sample)
  `AFSK_ASSERT_NXT(a_out_to_idle, clk_i, rst_ni, cmd_o.load_out, state_q == ST_IDLE)

endmodule

@@ rtl/core/afsk_dp.sv @@
// ---------------------------------------------------------------------------
// AFSK datapath
// Histories, shared multiply-accumulate, rounding, squaring and output.
// ---------------------------------------------------------------------------
module afsk_dp #(
  parameter int unsigned BpTaps     = 36,
  parameter int unsigned LpTaps     = 24,
  parameter int unsigned SampleBits = 12,
  parameter int unsigned CoeffBits  = 16,
  parameter int unsigned CntW       = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [SampleBits-1:0]    sample_i,
  input  logic [CntW-1:0]          tap_i,
  input  afsk_pkg::dp_cmd_t        cmd_i,
  input  logic                     out_take_i,
  output logic                     out_valid_o,
  output logic [17:0]              soft_o,
  output logic                     hard_o
);
  import afsk_pkg::*;

  localparam int unsigned AccW = 48;
  localparam int unsigned Frac = CoeffBits - 1;
  localparam int unsigned BpIdxW = $clog2(BpTaps);
  localparam int unsigned LpIdxW = $clog2(LpTaps);
  localparam int unsigned SumW = CntW + 1;
  localparam logic [BpIdxW-1:0] HeadLast = BpIdxW'(BpTaps - 1);

  // sample history: circular buffer, entries at or beyond the fill count read as zero
  logic signed [SampleBits-1:0] samp_mem [BpTaps];
  logic [15:0] sen_q [LpTaps];
  logic [15:0] men_q [LpTaps];

  logic [BpIdxW-1:0]            head_q;
  logic [BpIdxW-1:0]            head_d;
  logic [CntW-1:0]              fill_q;
  logic [SumW-1:0]              rd_sum_c;
  logic [BpIdxW-1:0]            rd_addr_c;
  logic signed [SampleBits-1:0] samp_rd_q;
  logic [15:0]                  en_sel_c;
  logic [15:0]                  en_rd_q;
  logic                         use_samp_q;
  logic                         zero_q;
  logic signed [17:0]           coef_c;
  logic signed [17:0]           coef_q;
  logic signed [16:0]           opnd_c;
  logic signed [AccW-1:0]       prod_c;
  logic signed [AccW-1:0]       acc_q;
  logic                         pv_q;
  logic                         pv_mark_q;
  logic signed [15:0]           ysat_c;
  logic signed [31:0]           ysq_c;
  logic [15:0]                  en_c;
  logic signed [AccW-1:0]       rnd_c;
  logic signed [AccW-1:0]       senv_q;
  logic signed [AccW-1:0]       menv_q;
  logic signed [AccW-1:0]       diff_c;
  logic [17:0]                  soft_q;
  logic                         hard_q;
  logic                         ov_q;

  always_comb begin
    coef_c = '0;
    if (int'(tap_i) < ((cmd_i.sel == SEL_ENV) ? LpDesign : BpDesign)) begin
      coef_c = coef_lookup(cmd_i.sel, int'(tap_i));
    end
  end

  // newest sample sits at head; tap t lives t entries behind it
  assign head_d = (head_q == HeadLast) ? '0 : head_q + 1'b1;
  assign rd_sum_c = SumW'(head_q) + SumW'(BpTaps) - SumW'(tap_i);
  assign rd_addr_c = (rd_sum_c >= SumW'(BpTaps)) ? BpIdxW'(rd_sum_c - SumW'(BpTaps))
                                                : BpIdxW'(rd_sum_c);

  // mark envelope pass is flagged by a register set after the space envelope
  assign en_sel_c = (tap_i < CntW'(LpTaps))
                  ? (pv_mark_q ? men_q[tap_i[LpIdxW-1:0]] : sen_q[tap_i[LpIdxW-1:0]])
                  : '0;

  assign opnd_c = use_samp_q ? (zero_q ? '0 : 17'(samp_rd_q))
                             : $signed({1'b0, en_rd_q});
  assign prod_c = AccW'(coef_q * opnd_c);

  // round half up: add half, arithmetic shift (floor)
  assign rnd_c = (acc_q + (AccW'(1) <<< (Frac - 1))) >>> Frac;
  assign ysat_c = (rnd_c > AccW'(32767)) ? 16'sd32767 :
                  (rnd_c < -AccW'(32768)) ? -16'sd32768 : rnd_c[15:0];
  assign ysq_c = ysat_c * ysat_c;
  assign en_c  = 16'(ysq_c[31:16]);
  assign diff_c = menv_q - senv_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_sample) samp_mem[head_d] <= sample_i;
    samp_rd_q <= samp_mem[rd_addr_c];
  end

  always_ff @(posedge clk_i) begin
    en_rd_q    <= en_sel_c;
    coef_q     <= coef_c;
    use_samp_q <= (cmd_i.sel != SEL_ENV);
    zero_q     <= (tap_i >= fill_q);
    if (cmd_i.clr_acc) acc_q <= '0;
    else if (pv_q) acc_q <= acc_q + prod_c;
    if (cmd_i.fin_space_env) senv_q <= rnd_c;
    if (cmd_i.fin_mark_env) menv_q <= rnd_c;
    if (cmd_i.load_out) begin
      if (diff_c > AccW'(131071)) soft_q <= 18'h1FFFF;
      else if (diff_c < -AccW'(131072)) soft_q <= 18'h20000;
      else soft_q <= diff_c[17:0];
      hard_q <= (diff_c > 0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      fill_q    <= '0;
      for (int i = 0; i < LpTaps; i++) begin
        sen_q[i] <= '0;
        men_q[i] <= '0;
      end
      pv_q      <= 1'b0;
      pv_mark_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      if (cmd_i.shift_sample) begin
        head_q <= head_d;
        if (fill_q < CntW'(BpTaps)) fill_q <= fill_q + 1'b1;
      end
      if (cmd_i.fin_space_bp) begin
        sen_q[0] <= en_c;
        for (int i = 1; i < LpTaps; i++) sen_q[i] <= sen_q[i-1];
      end
      if (cmd_i.fin_mark_bp) begin
        men_q[0] <= en_c;
        for (int i = 1; i < LpTaps; i++) men_q[i] <= men_q[i-1];
      end
      pv_q <= cmd_i.mac_en;
      if (cmd_i.fin_space_env) pv_mark_q <= 1'b1;
      else if (cmd_i.fin_mark_env) pv_mark_q <= 1'b0;
      if (cmd_i.load_out) ov_q <= 1'b1;
      else if (out_take_i) ov_q <= 1'b0;
    end
  end

  assign out_valid_o = ov_q;
  assign soft_o = soft_q;
  assign hard_o = hard_q;

  `include "afsk_envelope_demodulator_assert.svh"
  `AFSK_ASSERT_NXT(a_load_valid, clk_i, rst_ni, cmd_i.load_out, out_valid_o)
  `AFSK_ASSERT_IMP(a_hard_sign, clk_i, rst_ni, out_valid_o && hard_o, !soft_o[17])
  `AFSK_ASSERT_IMP(a_env_excl, clk_i, rst_ni, 1'b1, !(cmd_i.fin_space_env && cmd_i.fin_mark_env))

endmodule

@@ rtl/core/afsk_envelope_demodulator.sv @@
// Each item runs the space and mark band-pass passes, then the space and mark envelope passes.
// Throughput is set by the single shared MAC; no new item is taken while one is in flight.
// A new item is taken once the previous result has entered the output register.
// Reset (rst_ni low, asynchronous) clears control, energy histories and the sample fill count.
// ---------------------------------------------------------------------------
// AFSK envelope demodulator
// Band-pass, square, low-pass and decision over one shared MAC.
// ---------------------------------------------------------------------------
module afsk_envelope_demodulator #(
  parameter int unsigned BANDPASS_TAPS = 36,
  parameter int unsigned LOWPASS_TAPS  = 24,
  parameter int unsigned SAMPLE_BITS   = 12,
  parameter int unsigned COEFF_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [SAMPLE_BITS-1:0] sample
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [17:0] soft_decision, [18] hard_bit
);
  import afsk_pkg::*;

  localparam int unsigned MaxTaps = (BANDPASS_TAPS > LOWPASS_TAPS) ? BANDPASS_TAPS
                                                                   : LOWPASS_TAPS;
  localparam int unsigned CntW = $clog2(MaxTaps + 1);

  logic busy;
  logic [CntW-1:0] tap;
  dp_cmd_t cmd;
  logic [17:0] soft_dec;
  logic hard;
  logic in_fire;

  assign s_axis_tready = !busy;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  afsk_ctrl #(
    .BpTaps(BANDPASS_TAPS), .LpTaps(LOWPASS_TAPS), .CntW(CntW)
  ) u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire),
    .out_free_i(!m_axis_tvalid || m_axis_tready),
    .busy_o(busy), .tap_o(tap), .cmd_o(cmd)
  );

  afsk_dp #(
    .BpTaps(BANDPASS_TAPS), .LpTaps(LOWPASS_TAPS),
    .SampleBits(SAMPLE_BITS), .CoeffBits(COEFF_BITS), .CntW(CntW)
  ) u_dp (
    .clk_i, .rst_ni, .sample_i(s_axis_tdata[SAMPLE_BITS-1:0]),
    .tap_i(tap), .cmd_i(cmd), .out_take_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid), .soft_o(soft_dec), .hard_o(hard)
  );

  assign m_axis_tdata = {5'b0, hard, soft_dec};

endmodule

@@ sim/afsk_demod_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AFSK demodulator checker
// Watches both streams, predicts each decision from accepted samples and
// compares every result item field by field against the oldest prediction.
// ---------------------------------------------------------------------------
module afsk_demod_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [23:0] m_tdata_i,
  output int          err_cnt_o,
  output int          pending_o
);

  typedef struct packed {
    logic signed [17:0] soft_val;
    logic               hard;
  } decision_t;

  localparam int BpTaps  = 36;
  localparam int EnvTaps = 24;

  const int space_taps[BpTaps] = '{
    113, 86, 40, -57, -233, -501, -843, -1207, -1509, -1653, -1550, -1147,
    -445, 490, 1535, 2529, 3307, 3735, 3735, 3307, 2529, 1535, 490, -445,
    -1147, -1550, -1653, -1509, -1207, -843, -501, -233, -57, 40, 86, 113};
  const int mark_taps[BpTaps] = '{
    0, -111, -242, -344, -301, 0, 555, 1161, 1452, 1089, 0, -1483,
    -2701, -2976, -1984, 0, 2179, 3592, 3592, 2179, 0, -1984, -2976, -2701,
    -1483, 0, 1089, 1452, 1161, 555, 0, -301, -344, -242, -111, 0};
  const int smooth_taps[EnvTaps] = '{
    11, 45, 119, 267, 512, 861, 1303, 1802, 2309, 2762, 3104, 3288,
    3288, 3104, 2762, 2309, 1802, 1303, 861, 512, 267, 119, 45, 11};

  longint    samples[BpTaps];
  longint    space_pow[EnvTaps];
  longint    mark_pow[EnvTaps];
  decision_t decision_q[$];

  // round to nearest, ties up: floor((a + half) / 2^15)
  function automatic longint q15_round(longint a);
    return (a + 64'sd16384) >>> 15;
  endfunction

  function automatic longint tone_level(bit is_mark);
    longint acc;
    acc = 0;
    for (int i = 0; i < BpTaps; i++)
      acc += samples[i] * (is_mark ? mark_taps[i] : space_taps[i]);
    acc = q15_round(acc);
    if (acc > 32767) acc = 32767;
    if (acc < -32768) acc = -32768;
    return acc;
  endfunction

  function automatic decision_t predict_decision(logic signed [11:0] smp);
    longint    y_s, y_m, env_s, env_m, diff;
    decision_t d;
    for (int i = BpTaps - 1; i > 0; i--) samples[i] = samples[i-1];
    samples[0] = smp;
    y_s = tone_level(1'b0);
    y_m = tone_level(1'b1);
    for (int i = EnvTaps - 1; i > 0; i--) begin
      space_pow[i] = space_pow[i-1];
      mark_pow[i]  = mark_pow[i-1];
    end
    space_pow[0] = (y_s * y_s) >> 16;
    mark_pow[0]  = (y_m * y_m) >> 16;
    env_s = 0;
    env_m = 0;
    for (int i = 0; i < EnvTaps; i++) begin
      env_s += space_pow[i] * smooth_taps[i];
      env_m += mark_pow[i] * smooth_taps[i];
    end
    diff = q15_round(env_m) - q15_round(env_s);
    if (diff > 131071) diff = 131071;
    if (diff < -131072) diff = -131072;
    d.soft_val = diff[17:0];
    d.hard = diff > 0;
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    decision_t exp_d;
    int        errs;
    if (!rst_ni) begin
      for (int i = 0; i < BpTaps; i++) samples[i] = 0;
      for (int i = 0; i < EnvTaps; i++) begin
        space_pow[i] = 0;
        mark_pow[i]  = 0;
      end
      decision_q.delete();
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      errs = 0;
      if (m_tvalid_i && m_tready_i) begin
        if (decision_q.size() == 0) begin
          $display("%0t: unexpected item tdata=%h", $time, m_tdata_i);
          errs++;
        end else begin
          exp_d = decision_q.pop_front();
          if (m_tdata_i[17:0] !== exp_d.soft_val) begin
            $display("%0t: soft_decision expected %0d actual %0d", $time,
                     exp_d.soft_val, $signed(m_tdata_i[17:0]));
            errs++;
          end
          if (m_tdata_i[18] !== exp_d.hard) begin
            $display("%0t: hard_bit expected %0b actual %0b", $time,
                     exp_d.hard, m_tdata_i[18]);
            errs++;
          end
          if (m_tdata_i[23:19] !== 5'd0) begin
            $display("%0t: tdata padding expected 0 actual %h", $time,
                     m_tdata_i[23:19]);
            errs++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        decision_q.push_back(predict_decision(s_tdata_i[11:0]));
      err_cnt_o <= err_cnt_o + errs;
      pending_o <= decision_q.size();
    end
  end

endmodule

@@ sim/tb_afsk_envelope_demodulator.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// AFSK envelope demodulator testbench
// Feeds extremes, mark and space tone bursts and noise through the block
// under several idle and stall patterns; the checker scores the results.
// ---------------------------------------------------------------------------
module tb_afsk_envelope_demodulator;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [11:0] sample
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;       // [17:0] soft_decision, [18] hard_bit

  int  err_cnt, pending;
  int  tx_idle_pct = 0, rx_stall_pct = 0;
  bit  rx_hold = 1'b0;
  int  sent = 0;
  real phase = 0.0;

  always #5 clk_i = ~clk_i;

  afsk_envelope_demodulator DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  afsk_demod_checker u_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata),
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  always @(posedge clk_i)
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);

  task automatic send_sample(logic signed [11:0] smp);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'($urandom_range(15)), smp};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  // 12 kHz sample rate
  task automatic send_tone(int n, real freq, int amp);
    int v;
    for (int i = 0; i < n; i++) begin
      v = $rtoi(amp * $sin(phase));
      phase += 2.0 * 3.14159265358979 * freq / 12000.0;
      send_sample(12'(v));
    end
  endtask

  task automatic random_traffic(int upto);
    int kind;
    while (sent < upto) begin
      kind = $urandom_range(99);
      if (kind < 85)
        send_tone($urandom_range(8, 40), ($urandom_range(1) ? 2400.0 : 1200.0)
                  + $urandom_range(0, 200) - 100.0, $urandom_range(50, 2047));
      else
        repeat ($urandom_range(1, 10)) send_sample(12'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_sample(12'sd0);
    send_sample(12'sd2047);
    send_sample(-12'sd2048);
    send_sample(12'sd2047);
    send_sample(-12'sd2048);
    send_sample(12'h555);
    send_sample(12'haaa);
    send_tone(9, 2400.0, 2047);
    send_tone(9, 1200.0, 2047);

    fork
      begin
        rx_hold = 1'b1;
        repeat (3000) @(posedge clk_i);
        rx_hold = 1'b0;
      end
    join_none
    random_traffic(200);
    tx_idle_pct = 70;
    random_traffic(380);
    tx_idle_pct = 0;
    rx_stall_pct = 70;
    random_traffic(560);
    tx_idle_pct = 37;
    rx_stall_pct = 37;
    random_traffic(750);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (err_cnt == 0)
      $display("tb_afsk_envelope_demodulator: done, clean");
    else
      $display("tb_afsk_envelope_demodulator: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_afsk_envelope_demodulator: done, errors");
    $finish;
  end

endmodule
